@@ hw/rtl/ipm_pkg.sv @@
package ipm_pkg;

	// largest image side the line buffers hold
	localparam int MAX_SIDE = 32;
	// width of a row or column index
	localparam int POS_W = $clog2(MAX_SIDE);
	// width of a side value, which can equal MAX_SIDE
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	// width of the image_side register
	localparam int CFG_W = 6;
	localparam int MIN_SIDE = 2;

	// 3x3 window: bits 0..2 current row, 3..5 row above, 6..8 two rows above
	localparam int WIN_W = 9;
	localparam logic [WIN_W-1:0] WIN_MASK = 9'h1B6;
	localparam logic [WIN_W-1:0] WIN_ALONE = 9'h010;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int IN_TDATA_W = 8;
	localparam int OUT_FIELDS_W = 2 * POS_W + 2;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic clear;
		logic shift;
	} chain_ctl_t;

	typedef struct packed {
		logic older;
		logic newer;
	} lb_bits_t;

	typedef struct packed {
		logic last;
		logic isolated;
		logic pixel;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} res_t;

	typedef struct packed {
		logic room;
		logic [QCNT_W-1:0] level;
	} q_stat_t;

endpackage

@@ hw/rtl/ipm_cell.sv @@
module ipm_cell import ipm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  lb_bits_t   cell_d,
	output lb_bits_t   cell_q
);

	// one column of both line buffers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (ctl.clear) begin
			cell_q <= '0;
		end else if (ctl.shift) begin
			cell_q <= cell_d;
		end
	end

endmodule

@@ hw/rtl/ipm_line_chain.sv @@
module ipm_line_chain import ipm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  chain_ctl_t       ctl,
	input  logic             pixel,
	input  logic [POS_W-1:0] side_m1,
	output logic             older_tap,
	output logic             newer_tap
);

	lb_bits_t link_d [MAX_SIDE];
	lb_bits_t link_q [MAX_SIDE];
	lb_bits_t tap;

	// a bit leaves the chain exactly one image row after it entered
	assign tap = link_q[side_m1];
	assign older_tap = tap.older;
	assign newer_tap = tap.newer;

	// the row above drops into the older buffer as the new pixel enters
	assign link_d[0] = '{older: tap.newer, newer: pixel};

	genvar g;
	generate
		for (g = 1; g < MAX_SIDE; g++) begin : g_link
			assign link_d[g] = link_q[g-1];
		end
		for (g = 0; g < MAX_SIDE; g++) begin : g_cell
			ipm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.cell_d (link_d[g]),
				.cell_q (link_q[g])
			);
		end
	endgenerate

endmodule

@@ hw/rtl/ipm_window.sv @@
module ipm_window import ipm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_ctl_t ctl,
	input  logic       col_zero,
	input  logic       older,
	input  logic       newer,
	input  logic       pixel,
	output logic       ctr_pixel,
	output logic       ctr_isolated,
	output logic       edge_pixel,
	output logic       edge_isolated
);

	logic [WIN_W-1:0] win_q;
	logic [WIN_W-1:0] win_d;
	logic [WIN_W-1:0] win_edge;
	logic [WIN_W-1:0] win_prev;

	// columns left of the image read as clear
	assign win_prev = col_zero ? '0 : win_q;
	assign win_d = ((win_prev << 1) & WIN_MASK)
		| {2'b00, older, 2'b00, newer, 2'b00, pixel};
	// right edge pixel: shift once more with a clear column on the right
	assign win_edge = (win_d << 1) & WIN_MASK;

	assign ctr_pixel = win_d[4];
	assign ctr_isolated = (win_d == WIN_ALONE);
	assign edge_pixel = win_edge[4];
	assign edge_isolated = (win_edge == WIN_ALONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= win_d;
		end
	end

endmodule

@@ hw/rtl/ipm_out_queue.sv @@
module ipm_out_queue import ipm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       res0,
	input  res_t       res1,
	input  logic       m_ready,
	output logic       m_valid,
	output res_t       head,
	output q_stat_t    stat
);

	res_t ent_q [QDEPTH];
	res_t ent_d [QDEPTH];
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] base;
	logic pop;

	assign m_valid = (cnt_q != '0);
	assign pop = m_valid & m_ready;
	assign head = ent_q[0];
	assign base = cnt_q - QCNT_W'(pop);
	// room for two results whatever the receiver does this cycle
	assign stat.room = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign stat.level = cnt_q;

	always_comb begin
		for (int i = 0; i < QDEPTH - 1; i++) begin
			ent_d[i] = pop ? ent_q[i+1] : ent_q[i];
		end
		ent_d[QDEPTH-1] = ent_q[QDEPTH-1];
		for (int i = 0; i < QDEPTH; i++) begin
			if ((push_n != 2'd0) && (QCNT_W'(i) == base)) begin
				ent_d[i] = res0;
			end
			if ((push_n == 2'd2) && (QCNT_W'(i) == base + QCNT_W'(1))) begin
				ent_d[i] = res1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + QCNT_W'(push_n);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> ({1'b0, base} + (QCNT_W+1)'(push_n) <= (QCNT_W+1)'(QDEPTH)))
		else $error("result queue overflow");
`endif

endmodule

@@ hw/rtl/isolated_pixel_marker.sv @@
// isolated pixel marker, 3x3 neighborhood on a square binary image
//
// input channel s_*: one pixel per item in raster order, s_tdata[0] is the
// pixel, s_tlast marks the final pixel of the image. s_tlast on any other
// pixel drops the image in progress; no further results come for it.
// output channel m_*: one result per pixel in raster order with its row,
// column, value and isolated flag; m_tlast marks the bottom-right pixel.
// cfg_we/cfg_wdata set the image side (clamped to 2..32) and restart the
// image; write it only while the block is idle.
//
// a result for pixel (r-1, c-1) appears in the cycle after pixel (r, c) is
// accepted, given an empty result queue. outside the flush, and while the
// receiver keeps up, the block takes one pixel per cycle: the four-entry
// result queue soaks up the two results at each row end in the slot left
// by the first pixel of the next row. after the final pixel a flush runs
// one step per column of the last row, during which s_tready is low and
// the last row drains from the line chain. when the receiver stalls the
// queue fills and s_tready drops once fewer than two entries are free.
// reset sets the side to 32 and clears the line chain, window and position.
module isolated_pixel_marker import ipm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_wdata,   // image_side
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,     // [0] pixel_in
	input  logic                   s_tlast,     // end_of_image
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,     // row_out, col_out, pixel_out, isolated
	output logic                   m_tlast      // last_out
);

	logic [SIDE_W-1:0] side_q;
	logic [POS_W-1:0]  row_q;
	logic [POS_W-1:0]  col_q;
	logic              flush_q;

	logic [POS_W-1:0]  side_m1;
	logic              accept;
	logic              final_pix;
	logic              drop;
	logic              step;
	logic              last_col;
	logic              flush_end;
	logic              has_row;
	logic              k_ctr;
	logic              k_edge;
	logic              pixel;
	logic              older_tap;
	logic              newer_tap;
	logic              ctr_pixel;
	logic              ctr_isolated;
	logic              edge_pixel;
	logic              edge_isolated;
	logic [1:0]        push_n;
	chain_ctl_t        ctl;
	q_stat_t           stat;
	res_t              res_ctr;
	res_t              res_edge;
	res_t              head;

	// register value outside 2..MAX_SIDE is pulled to the nearest end
	function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_W-1:0] v);
		logic [SIDE_W-1:0] s;
		if (v < CFG_W'(MIN_SIDE)) begin
			s = SIDE_W'(MIN_SIDE);
		end else if (v > CFG_W'(MAX_SIDE)) begin
			s = SIDE_W'(MAX_SIDE);
		end else begin
			s = SIDE_W'(v);
		end
		return s;
	endfunction

	assign side_m1 = POS_W'(side_q - SIDE_W'(1));
	assign last_col = (col_q == side_m1);
	assign final_pix = (row_q == side_m1) && last_col;

	// no input during the flush of the last row
	assign s_tready = stat.room & ~flush_q;
	assign accept = s_tvalid & s_tready;
	// early end of image: throw the image away
	assign drop = accept & s_tlast & ~final_pix;
	// a step is a real pixel or a clear pixel of the virtual row below the image
	assign step = (accept & ~drop) | (flush_q & stat.room);
	assign flush_end = flush_q & stat.room & last_col;

	assign ctl.shift = step;
	assign ctl.clear = cfg_we | drop | flush_end;
	assign pixel = flush_q ? 1'b0 : s_tdata[0];

	// nothing to report while the first row streams in
	assign has_row = flush_q | (row_q != '0);
	assign k_ctr = step & has_row & (col_q != '0);
	assign k_edge = step & has_row & last_col;
	// the edge result always comes with a center result
	assign push_n = {k_edge, k_ctr & ~k_edge};

	ipm_line_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.pixel     (pixel),
		.side_m1   (side_m1),
		.older_tap (older_tap),
		.newer_tap (newer_tap)
	);

	ipm_window u_window (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.col_zero      (col_q == '0),
		.older         (older_tap),
		.newer         (newer_tap),
		.pixel         (pixel),
		.ctr_pixel     (ctr_pixel),
		.ctr_isolated  (ctr_isolated),
		.edge_pixel    (edge_pixel),
		.edge_isolated (edge_isolated)
	);

	// center of the window sits one row up and one column left, but in the
	// flush the row counter already holds the last image row
	assign res_ctr.row = flush_q ? row_q : row_q - POS_W'(1);
	assign res_ctr.col = col_q - POS_W'(1);
	assign res_ctr.pixel = ctr_pixel;
	assign res_ctr.isolated = ctr_isolated;
	assign res_ctr.last = 1'b0;

	// right edge pixel of the same row
	assign res_edge.row = res_ctr.row;
	assign res_edge.col = col_q;
	assign res_edge.pixel = edge_pixel;
	assign res_edge.isolated = edge_isolated;
	assign res_edge.last = flush_q;

	ipm_out_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_n  (push_n),
		.res0    (res_ctr),
		.res1    (res_edge),
		.m_ready (m_tready),
		.m_valid (m_tvalid),
		.head    (head),
		.stat    (stat)
	);

	assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
		head.isolated, head.pixel, head.col, head.row};
	assign m_tlast = head.last;

	// side register, raster position and flush flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_W'(MAX_SIDE);
			row_q <= '0;
			col_q <= '0;
			flush_q <= 1'b0;
		end else if (cfg_we) begin
			side_q <= side_clamp(cfg_wdata);
			row_q <= '0;
			col_q <= '0;
			flush_q <= 1'b0;
		end else if (drop || flush_end) begin
			row_q <= '0;
			col_q <= '0;
			flush_q <= 1'b0;
		end else if (step) begin
			if (flush_q) begin
				col_q <= col_q + POS_W'(1);
			end else if (final_pix) begin
				// final pixel starts the flush of the last row
				flush_q <= 1'b1;
				col_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !s_tready)
		else $error("pixel accepted during flush");

	a_flush_ends_clean: assert property (@(posedge clk) disable iff (!arst_n)
		flush_end |=> (!flush_q && row_q == '0 && col_q == '0))
		else $error("flush did not restart the image");
`endif

endmodule
